// ===== hdl/fpa_pkg.sv =====
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DW        = 33 + FRAC_BITS;  // divider dividend/quotient width
   localparam int QDEPTH    = 2;

   typedef enum logic [2:0] {
      MODE_ADD = 3'd0,
      MODE_SUB = 3'd1,
      MODE_MUL = 3'd2,
      MODE_DIV = 3'd3,
      MODE_MIN = 3'd4,
      MODE_MAX = 3'd5,
      MODE_INC = 3'd6,
      MODE_DEC = 3'd7
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic               a_less;
      logic               a_equal;
      logic               a_greater;
      logic               overflow;
      logic               divide_by_zero;
   } rsp_type;

   typedef struct packed {
      mode_type           mode;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic               lt;
      logic               eq;
      logic               gt;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic [31:0] res;
      logic        ovf;
   } sat_type;

   localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
   localparam logic [31:0] MIN32 = 32'h8000_0000;

   function automatic sat_type sat_add(input logic [32:0] s);
      sat_type r;
      r.ovf = s[32] ^ s[31];
      if (r.ovf) begin
         r.res = s[32] ? MIN32 : MAX32;
      end else begin
         r.res = s[31:0];
      end
      return r;
   endfunction

   function automatic sat_type sat_mag(input logic [63:0] mag, input logic neg);
      sat_type r;
      if (neg) begin
         r.ovf = mag > 64'h0000_0000_8000_0000;
         r.res = r.ovf ? MIN32 : 32'(-mag[31:0]);
      end else begin
         r.ovf = mag > 64'h0000_0000_7FFF_FFFF;
         r.res = r.ovf ? MAX32 : mag[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/fpa_front.sv =====
module fpa_front
   import fpa_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  req_type   req_data,
   input  qstat_type qstat,
   output logic      busy,
   output logic      push,
   output item_type  push_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign busy   = qstat.full && valid_ff;
   assign accept = start && !busy;

   always_comb begin
      valid_in       = accept;
      item_in.mode   = req_data.mode;
      item_in.a      = req_data.operand_a;
      item_in.b      = req_data.operand_b;
      item_in.lt     = req_data.operand_a <  req_data.operand_b;
      item_in.eq     = req_data.operand_a == req_data.operand_b;
      item_in.gt     = req_data.operand_a >  req_data.operand_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign push      = valid_ff;
   assign push_item = item_ff;

endmodule

// ===== hdl/fpa_queue.sv =====
module fpa_queue
   import fpa_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   input  logic      pop,
   output item_type  pop_item,
   output qstat_type qstat
);

   localparam int AW = $clog2(QDEPTH);

   item_type        mem [QDEPTH];
   logic [AW-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [AW:0]     count_ff, count_in;
   logic            do_push, do_pop;

   assign qstat.full  = count_ff == (AW+1)'(QDEPTH);
   assign qstat.empty = count_ff == '0;
   assign do_pop      = pop && !qstat.empty;
   assign do_push     = push && (!qstat.full || do_pop);
   assign pop_item    = mem[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? AW'((wptr_ff + 1'b1) % QDEPTH) : wptr_ff;
      rptr_in  = do_pop  ? AW'((rptr_ff + 1'b1) % QDEPTH) : rptr_ff;
      count_in = count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem[wptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/fpa_back.sv =====
module fpa_back
   import fpa_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  qstat_type qstat,
   input  item_type  pop_item,
   output logic      pop,
   output logic      rsp_valid,
   output rsp_type   rsp_data
);

   typedef struct packed {
      mode_type    mode;
      logic        neg;
      logic        lt;
      logic        eq;
      logic        gt;
      logic        dz;
      logic [31:0] res;
      logic        ovf;
   } ctrl_type;

   logic [DW:0]        vld_ff;
   ctrl_type           ctrl_ff [DW+1];
   logic [32:0]        rem_ff  [DW+1];
   logic [DW-1:0]      nq_ff   [DW+1];
   logic [32:0]        den_ff  [DW+1];
   logic signed [63:0] prod_ff;

   ctrl_type    ctrl0_in;
   logic [31:0] ma, mb;
   logic [DW-1:0] num0;
   sat_type     simple;

   assign pop = !qstat.empty;

   // stage 0: operand prep, simple ops, multiply
   always_comb begin
      ma   = pop_item.a[31] ? 32'(-pop_item.a) : pop_item.a;
      mb   = pop_item.b[31] ? 32'(-pop_item.b) : pop_item.b;
      num0 = DW'({ma, {FRAC_BITS{1'b0}}, 1'b0}) + DW'(mb);
      simple = '0;
      unique case (pop_item.mode)
         MODE_ADD: simple = sat_add({pop_item.a[31], pop_item.a} + {pop_item.b[31], pop_item.b});
         MODE_SUB: simple = sat_add({pop_item.a[31], pop_item.a} - {pop_item.b[31], pop_item.b});
         MODE_INC: simple = sat_add({pop_item.a[31], pop_item.a} + 33'd1);
         MODE_DEC: simple = sat_add({pop_item.a[31], pop_item.a} - 33'd1);
         MODE_MIN: simple.res = pop_item.lt ? pop_item.a : pop_item.b;
         MODE_MAX: simple.res = pop_item.gt ? pop_item.a : pop_item.b;
         MODE_MUL, MODE_DIV: simple = '0;
         default: simple = '0;
      endcase
      ctrl0_in.mode = pop_item.mode;
      ctrl0_in.neg  = pop_item.a[31] ^ pop_item.b[31];
      ctrl0_in.lt   = pop_item.lt;
      ctrl0_in.eq   = pop_item.eq;
      ctrl0_in.gt   = pop_item.gt;
      ctrl0_in.dz   = (pop_item.mode == MODE_DIV) && (pop_item.b == '0);
      ctrl0_in.res  = simple.res;
      ctrl0_in.ovf  = simple.ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= pop;
      end
      ctrl_ff[0] <= ctrl0_in;
      rem_ff[0]  <= '0;
      nq_ff[0]   <= num0;
      den_ff[0]  <= {mb, 1'b0};
      prod_ff    <= 64'(pop_item.a) * 64'(pop_item.b);
   end

   // restoring divider, one quotient bit per stage
   for (genvar i = 0; i < DW; i++) begin : g_div
      logic [33:0] trial, diff;
      logic        ge;
      logic [63:0] pmag;
      sat_type     psat;
      ctrl_type    ctrl_in;

      always_comb begin
         trial   = {rem_ff[i], nq_ff[i][DW-1]};
         diff    = trial - {1'b0, den_ff[i]};
         ge      = trial >= {1'b0, den_ff[i]};
         pmag    = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
         psat    = sat_mag((pmag + 64'(1 << (FRAC_BITS - 1))) >> FRAC_BITS, prod_ff[63]);
         ctrl_in = ctrl_ff[i];
         if (i == 0 && ctrl_ff[i].mode == MODE_MUL) begin
            ctrl_in.res = psat.res;
            ctrl_in.ovf = psat.ovf;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         ctrl_ff[i+1] <= ctrl_in;
         rem_ff[i+1]  <= ge ? diff[32:0] : trial[32:0];
         nq_ff[i+1]   <= {nq_ff[i][DW-2:0], ge};
         den_ff[i+1]  <= den_ff[i];
      end
   end

   ctrl_type fin;
   sat_type  qsat;
   rsp_type  rsp_in;
   logic     rsp_valid_ff;
   rsp_type  rsp_ff;

   always_comb begin
      fin  = ctrl_ff[DW];
      qsat = sat_mag(64'(nq_ff[DW]), fin.neg);
      rsp_in.result         = fin.res;
      rsp_in.overflow       = fin.ovf;
      rsp_in.a_less         = fin.lt;
      rsp_in.a_equal        = fin.eq;
      rsp_in.a_greater      = fin.gt;
      rsp_in.divide_by_zero = fin.dz;
      if (fin.mode == MODE_DIV) begin
         rsp_in.result   = fin.dz ? '0 : qsat.res;
         rsp_in.overflow = !fin.dz && qsat.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[DW];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/fixed_point_alu_top.sv =====
// channel | ports                      | handshake
// request | start, busy, req_data      | beat taken when start && !busy
// result  | rsp_valid, rsp_data        | one-cycle strobe, cannot be held off
//
// One item per cycle sustained. A Q24.8 item in any mode passes the front
// register, queue, stage 0, the divider stages (one quotient bit per stage)
// and the result register. Reset is synchronous, active high, and empties
// front, queue and pipeline. The back end never stalls, so busy stays low.
module fixed_point_alu_top
   import fpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int LAT = DW + 4;

   qstat_type qstat;
   logic      push, pop;
   item_type  push_item, pop_item;

   fpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .qstat     (qstat),
      .busy      (busy),
      .push      (push),
      .push_item (push_item)
   );

   fpa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .qstat     (qstat)
   );

   fpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .pop_item  (pop_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_valid)
      else $error("result missing at fixed latency");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_data.a_less, rsp_data.a_equal, rsp_data.a_greater}))
      else $error("compare flags not one-hot");

   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |-> rsp_data.result == '0 && !rsp_data.overflow)
      else $error("divide by zero result wrong");

endmodule
